[rtl/ftc_pkg.sv]
// shared types and constants for the frame traffic classifier
package ftc_pkg;

    localparam int POS_W = 12;
    localparam int OFF_W = 13;

    localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 12'd4095;
    localparam logic [POS_W-1:0] HEADER_BYTES    = 12'd30;
    localparam logic [POS_W-1:0] MIN_PAYLOAD     = 12'd20;
    localparam logic [POS_W-1:0] PORT_MARGIN     = 12'd4;
    localparam logic [POS_W-1:0] TEXT_MARGIN     = 12'd10;
    localparam logic [OFF_W-1:0] NONE_FOUND      = 13'h1FFF;

    localparam logic [55:0] TXT_MONITOR = 56'h6D6F6E69746F72;
    localparam logic [31:0] TXT_MQTT    = 32'h4D515454;
    localparam logic [39:0] TXT_ALERT   = 40'h616C657274;

    localparam logic [47:0]      OWN_MAC_RST    = 48'd0;
    localparam logic [15:0]      PORT_VALUE_RST = 16'd1883;
    localparam logic [POS_W-1:0] LIMIT_RST      = 12'd100;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_IMG_START = 2'd1,
        OP_IMG_END   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        REG_OWN_MAC    = 2'd0,
        REG_PORT_VALUE = 2'd1,
        REG_LONG_LIMIT = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ENT_FRAME,
        ENT_IMG_START,
        ENT_IMG_END
    } ent_kind_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] frame_byte;
        logic       is_data_frame;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        frame_counted;
        logic        own_frame;
        logic        marked_frame;
        logic [11:0] frame_length;
        logic [31:0] total_frames;
        logic [63:0] total_octets;
        logic [31:0] marked_frames;
        logic [63:0] marked_octets;
        logic [31:0] image_frames;
        logic [63:0] image_octets;
    } result_t;

    // verdict or window event handed from front to back
    typedef struct packed {
        ent_kind_t        kind;
        logic             counted;
        logic             own;
        logic             marked;
        logic [POS_W-1:0] len;
    } entry_t;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] r;
        begin
            case (k)
                3'd0:    r = mac[47:40];
                3'd1:    r = mac[39:32];
                3'd2:    r = mac[31:24];
                3'd3:    r = mac[23:16];
                3'd4:    r = mac[15:8];
                3'd5:    r = mac[7:0];
                default: r = 8'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/ftc_front.sv]
// front end: per-byte header compare, payload search and frame verdict
module ftc_front
    import ftc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         push,
    input  item_t        item,
    input  logic         full,
    output logic         q_push,
    output entry_t       q_word
);

    logic [47:0]      own_mac_reg;
    logic [15:0]      port_value_reg;
    logic [POS_W-1:0] limit_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dts_reg, dts_next;
    logic             a1_reg, a1_next;
    logic             a2_reg, a2_next;
    logic [55:0]      recent_reg, recent_next;
    logic [OFF_W-1:0] port_off_reg, port_off_next;
    logic [OFF_W-1:0] text_off_reg, text_off_next;

    logic             acc;
    logic [7:0]       b;
    logic [POS_W-1:0] q;
    logic [OFF_W-1:0] t;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] dlen;
    logic             counted;
    logic             own;
    logic             marked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg    <= OWN_MAC_RST;
            port_value_reg <= PORT_VALUE_RST;
            limit_reg      <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_MAC:    own_mac_reg    <= cfg_data;
                REG_PORT_VALUE: port_value_reg <= cfg_data[15:0];
                REG_LONG_LIMIT: limit_reg      <= cfg_data[POS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        acc           = push && !full;
        b             = item.frame_byte;
        q             = pos_reg - HEADER_BYTES;
        t             = text_off_reg;
        pos_next      = pos_reg;
        dts_next      = dts_reg;
        a1_next       = a1_reg;
        a2_next       = a2_reg;
        recent_next   = recent_reg;
        port_off_next = port_off_reg;
        text_off_next = text_off_reg;
        len           = '0;
        dlen          = '0;
        counted       = 1'b0;
        own           = 1'b0;
        marked        = 1'b0;
        q_push        = 1'b0;
        q_word        = '{kind: ENT_FRAME, counted: 1'b0, own: 1'b0, marked: 1'b0, len: '0};

        if (acc && item.opcode == OP_BYTE)
        begin
            // bytes past the maximum length are dropped
            if (pos_reg != MAX_FRAME_BYTES)
            begin
                if (pos_reg == '0)
                    dts_next = item.is_data_frame;
                if (pos_reg >= 12'd4 && pos_reg <= 12'd9
                    && b != mac_byte(own_mac_reg, 3'(pos_reg - 12'd4)))
                    a1_next = 1'b0;
                if (pos_reg >= 12'd10 && pos_reg <= 12'd15
                    && b != mac_byte(own_mac_reg, 3'(pos_reg - 12'd10)))
                    a2_next = 1'b0;
                recent_next = {recent_reg[47:0], b};
                if (pos_reg >= HEADER_BYTES)
                begin
                    if (q != '0 && port_off_reg == NONE_FOUND
                        && ((recent_reg[7:0] == port_value_reg[15:8] && b == port_value_reg[7:0])
                         || (recent_reg[7:0] == port_value_reg[7:0] && b == port_value_reg[15:8])))
                        port_off_next = {1'b0, q - 12'd1};
                    // keep the earliest text start
                    if (recent_next == TXT_MONITOR && q >= 12'd6 && {1'b0, q - 12'd6} < t)
                        t = {1'b0, q - 12'd6};
                    if (recent_next[31:0] == TXT_MQTT && q >= 12'd3 && {1'b0, q - 12'd3} < t)
                        t = {1'b0, q - 12'd3};
                    if (recent_next[39:0] == TXT_ALERT && q >= 12'd4 && {1'b0, q - 12'd4} < t)
                        t = {1'b0, q - 12'd4};
                    text_off_next = t;
                end
                pos_next = pos_reg + 12'd1;
            end

            if (item.last_byte)
            begin
                len     = pos_next;
                dlen    = len - HEADER_BYTES;
                counted = dts_next && len >= HEADER_BYTES;
                own     = counted && (a1_next || a2_next);
                marked  = own && dlen > MIN_PAYLOAD
                          && ((port_off_next < {1'b0, dlen - PORT_MARGIN})
                           || (len > limit_reg)
                           || (text_off_next < {1'b0, dlen - TEXT_MARGIN}));
                q_push  = 1'b1;
                q_word  = '{kind: ENT_FRAME, counted: counted, own: own,
                            marked: marked, len: len};
                pos_next      = '0;
                dts_next      = 1'b0;
                a1_next       = 1'b1;
                a2_next       = 1'b1;
                recent_next   = '0;
                port_off_next = NONE_FOUND;
                text_off_next = NONE_FOUND;
            end
        end
        else if (acc && item.opcode == OP_IMG_START)
        begin
            q_push      = 1'b1;
            q_word.kind = ENT_IMG_START;
        end
        else if (acc && item.opcode == OP_IMG_END)
        begin
            q_push      = 1'b1;
            q_word.kind = ENT_IMG_END;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            dts_reg      <= 1'b0;
            a1_reg       <= 1'b1;
            a2_reg       <= 1'b1;
            recent_reg   <= '0;
            port_off_reg <= NONE_FOUND;
            text_off_reg <= NONE_FOUND;
        end
        else
        begin
            pos_reg      <= pos_next;
            dts_reg      <= dts_next;
            a1_reg       <= a1_next;
            a2_reg       <= a2_next;
            recent_reg   <= recent_next;
            port_off_reg <= port_off_next;
            text_off_reg <= text_off_next;
        end
    end

endmodule

[rtl/ftc_queue.sv]
// short queue of verdicts and window events between front and back
module ftc_queue
    import ftc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_word,
    output logic   full,
    input  logic   rd,
    output entry_t rd_word,
    output logic   empty
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_wr;
    logic                do_rd;

    always_comb
    begin
        full        = cnt_reg == QCNT_W'(QUEUE_DEPTH);
        empty       = cnt_reg == '0;
        rd_word     = mem_reg[rd_ptr_reg];
        do_wr       = wr && !full;
        do_rd       = rd && !empty;
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[rtl/ftc_back.sv]
// back end: traffic counters, image window and result register
module ftc_back
    import ftc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  entry_t  q_word,
    output logic    q_pop,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic [31:0] fc_reg, fc_next;
    logic [63:0] oc_reg, oc_next;
    logic [31:0] mc_reg, mc_next;
    logic [63:0] mo_reg, mo_next;
    logic [31:0] ic_reg, ic_next;
    logic [63:0] io_reg, io_next;
    logic        win_reg, win_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        out_free;
    logic [63:0] len64;

    always_comb
    begin
        out_free       = !out_valid_reg || pop;
        q_pop          = !q_empty && (q_word.kind != ENT_FRAME || out_free);
        len64          = {52'd0, q_word.len};
        fc_next        = fc_reg;
        oc_next        = oc_reg;
        mc_next        = mc_reg;
        mo_next        = mo_reg;
        ic_next        = ic_reg;
        io_next        = io_reg;
        win_next       = win_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;

        if (q_pop)
        begin
            case (q_word.kind)
                ENT_FRAME:
                begin
                    if (q_word.counted)
                    begin
                        fc_next = fc_reg + 32'd1;
                        oc_next = oc_reg + len64;
                    end
                    if (q_word.marked)
                    begin
                        mc_next = mc_reg + 32'd1;
                        mo_next = mo_reg + len64;
                        if (win_reg)
                        begin
                            ic_next = ic_reg + 32'd1;
                            io_next = io_reg + len64;
                        end
                    end
                    out_valid_next = 1'b1;
                    out_next = '{frame_counted: q_word.counted, own_frame: q_word.own,
                                 marked_frame: q_word.marked, frame_length: q_word.len,
                                 total_frames: fc_next, total_octets: oc_next,
                                 marked_frames: mc_next, marked_octets: mo_next,
                                 image_frames: ic_next, image_octets: io_next};
                end
                ENT_IMG_START:
                begin
                    win_next = 1'b1;
                    ic_next  = '0;
                    io_next  = '0;
                end
                ENT_IMG_END:
                    win_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg        <= '0;
            oc_reg        <= '0;
            mc_reg        <= '0;
            mo_reg        <= '0;
            ic_reg        <= '0;
            io_reg        <= '0;
            win_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fc_reg        <= fc_next;
            oc_reg        <= oc_next;
            mc_reg        <= mc_next;
            mo_reg        <= mo_next;
            ic_reg        <= ic_next;
            io_reg        <= io_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

[rtl/frame_traffic_classifier_top.sv]
// top level of the frame traffic classifier
//
//  channel   ports                           handshake
//  input     item, push, full                word taken when push && !full
//  result    result, empty, pop              word taken when pop && !empty
//  config    cfg_we, cfg_index, cfg_data     written when cfg_we
//
// one input word per cycle while full is low; a final byte's verdict goes into
// the queue, then the back end updates the counters and registers the result
// the four-entry queue between front and back and the result register let
// input continue while a result waits; full rises only when the queue fills
// reset clears all counters, the image window and per-frame state
module frame_traffic_classifier_top
    import ftc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        push,
    input  item_t       item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output result_t     result
);

    logic   q_push;
    entry_t q_wr_word;
    logic   q_pop;
    entry_t q_rd_word;
    logic   q_empty;

    ftc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .q_push    (q_push),
        .q_word    (q_wr_word)
    );

    ftc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_word (q_wr_word),
        .full    (full),
        .rd      (q_pop),
        .rd_word (q_rd_word),
        .empty   (q_empty)
    );

    ftc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_word  (q_rd_word),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
